>>> hw/rtl/v3n_pkg.sv
// Shared types and constants for the vector normalization pipeline.
package v3n_pkg;

  localparam int CompW     = 32;
  localparam int UnitShift = 30;
  localparam int NumW      = CompW + UnitShift;
  localparam int SqrtCells = 32;
  localparam int DivCells  = NumW;
  localparam int ThreshW   = 17;
  localparam int PreStages = 4;
  localparam int VldLen    = PreStages + SqrtCells + 1 + DivCells;

  typedef logic [CompW-1:0] comp_t;

  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0][CompW-1:0] mag;
  } side_t;

endpackage

>>> hw/rtl/v3n_sqrt_cell.sv
// One step of the pipelined integer square root: one root bit per cell.
module v3n_sqrt_cell import v3n_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad_i,
  input  logic [33:0] rem_i,
  input  logic [31:0] root_i,
  input  side_t       side_i,
  output logic [63:0] rad_r,
  output logic [33:0] rem_r,
  output logic [31:0] root_r,
  output side_t       side_r
);

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] diff;
  logic [33:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_i, rad_i[63:62]};
    trial   = {2'b00, root_i, 2'b01};
    ge      = (rem_sh >= trial);
    diff    = rem_sh - trial;
    rem_nxt = ge ? diff[33:0] : rem_sh[33:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[61:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_i[30:0], ge};
      side_r <= side_i;
    end
  end

endmodule

>>> hw/rtl/v3n_div_cell.sv
// One step of the pipelined restoring divider: one quotient bit per cell.
module v3n_div_cell import v3n_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NumW-1:0]  num_i,
  input  logic [31:0]      rem_i,
  input  logic [31:0]      quo_i,
  input  logic [31:0]      len_i,
  output logic [NumW-1:0]  num_r,
  output logic [31:0]      rem_r,
  output logic [31:0]      quo_r
);

  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_i, num_i[NumW-1]};
    diff   = rem_sh - {1'b0, len_i};
    ge     = (rem_sh >= {1'b0, len_i});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= {num_i[NumW-2:0], 1'b0};
      rem_r <= ge ? diff[31:0] : rem_sh[31:0];
      quo_r <= {quo_i[30:0], ge};
    end
  end

endmodule

>>> hw/rtl/vector3_normalize_top.sv
// Top level of the 3D vector normalizer: squares, root chain, divider chains.
// Throughput: one request per cycle while not stalled; the whole pipeline advances together.
// The pipeline holds only while a result sits in the output register under stall.
// Reset (synchronous, active low) clears all valid bits and sets the threshold to 1.
// Datapath registers carry no reset; only their valid bits matter.
module vector3_normalize_top import v3n_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [ThreshW-1:0] cfg_zero_threshold,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_x_in,
  input  logic signed [31:0] in_y_in,
  input  logic signed [31:0] in_z_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x_unit,
  output logic signed [31:0] out_y_unit,
  output logic signed [31:0] out_z_unit,
  output logic        [31:0] out_length_out,
  output logic               out_zero_vector
);

  // Global advance: everything moves unless the output register is held.
  logic en;
  logic [VldLen-1:0] vld_r;
  logic              out_valid_r;
  logic [ThreshW-1:0] thresh_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      thresh_r    <= ThreshW'(1);
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_zero_threshold;
      end
      if (en) begin
        vld_r       <= {vld_r[VldLen-2:0], in_valid};
        out_valid_r <= vld_r[VldLen-1];
      end
    end
  end

  // Stage 1: split each component into sign and magnitude.
  // The most negative value has magnitude 2^31, which the 32-bit negation gives.
  side_t s1_r;
  comp_t comps [3];
  assign comps[0] = in_x_in;
  assign comps[1] = in_y_in;
  assign comps[2] = in_z_in;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_r.neg[i] <= comps[i][CompW-1];
        s1_r.mag[i] <= comps[i][CompW-1] ? (~comps[i] + comp_t'(1)) : comps[i];
      end
    end
  end

  // Stage 2: three 32x32 squares.
  logic [2:0][63:0] sq_r;
  side_t            s2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= {32'd0, s1_r.mag[i]} * {32'd0, s1_r.mag[i]};
      end
      s2_r <= s1_r;
    end
  end

  // Stages 3 and 4: sum of squares, which always fits in 64 bits.
  logic [63:0] s01_r;
  logic [63:0] sq2_r;
  side_t       s3_r;
  logic [63:0] sum_r;
  side_t       s4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s01_r <= sq_r[0] + sq_r[1];
      sq2_r <= sq_r[2];
      s3_r  <= s2_r;
      sum_r <= s01_r + sq2_r;
      s4_r  <= s3_r;
    end
  end

  // Square root chain: each cell settles one root bit.
  logic [63:0] rad_a  [SqrtCells+1];
  logic [33:0] rem_a  [SqrtCells+1];
  logic [31:0] root_a [SqrtCells+1];
  side_t       side_a [SqrtCells+1];

  assign rad_a[0]  = sum_r;
  assign rem_a[0]  = '0;
  assign root_a[0] = '0;
  assign side_a[0] = s4_r;

  for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (rad_a[k]),
      .rem_i  (rem_a[k]),
      .root_i (root_a[k]),
      .side_i (side_a[k]),
      .rad_r  (rad_a[k+1]),
      .rem_r  (rem_a[k+1]),
      .root_r (root_a[k+1]),
      .side_r (side_a[k+1])
    );
  end

  // Threshold stage: decide the zero case and load the divider numerators.
  // A length of zero always counts as a zero vector.
  logic [31:0]      len_a  [DivCells+1];
  logic             zero_a [DivCells+1];
  logic [2:0]       neg_a  [DivCells+1];
  logic [NumW-1:0]  num_a  [3][DivCells+1];
  logic [31:0]      drem_a [3][DivCells+1];
  logic [31:0]      quo_a  [3][DivCells+1];
  logic [31:0]      len0_r;
  logic             zero0_r;
  logic [2:0]       neg0_r;
  logic [2:0][NumW-1:0] num0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      len0_r  <= root_a[SqrtCells];
      zero0_r <= (root_a[SqrtCells] == 32'd0) ||
                 (root_a[SqrtCells] < {{(32-ThreshW){1'b0}}, thresh_r});
      neg0_r  <= side_a[SqrtCells].neg;
      for (int i = 0; i < 3; i++) begin
        num0_r[i] <= {side_a[SqrtCells].mag[i], {UnitShift{1'b0}}};
      end
    end
  end

  assign len_a[0]  = len0_r;
  assign zero_a[0] = zero0_r;
  assign neg_a[0]  = neg0_r;

  // Length, zero flag and signs travel beside the divider cells.
  for (genvar k = 0; k < DivCells; k++) begin : g_meta
    always_ff @(posedge clk) begin
      if (en) begin
        len_a[k+1]  <= len_a[k];
        zero_a[k+1] <= zero_a[k];
        neg_a[k+1]  <= neg_a[k];
      end
    end
  end

  // Three divider chains; only the low 32 quotient bits are kept.
  for (genvar c = 0; c < 3; c++) begin : g_comp
    assign num_a[c][0]  = num0_r[c];
    assign drem_a[c][0] = '0;
    assign quo_a[c][0]  = '0;
    for (genvar k = 0; k < DivCells; k++) begin : g_div
      v3n_div_cell u_cell (
        .clk   (clk),
        .en    (en),
        .num_i (num_a[c][k]),
        .rem_i (drem_a[c][k]),
        .quo_i (quo_a[c][k]),
        .len_i (len_a[k]),
        .num_r (num_a[c][k+1]),
        .rem_r (drem_a[c][k+1]),
        .quo_r (quo_a[c][k+1])
      );
    end
  end

  // Output register: restore signs, force zeros for a degenerate vector.
  logic [2:0][31:0] unit_r;
  logic [31:0]      len_out_r;
  logic             zero_out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_a[DivCells]) begin
          unit_r[i] <= '0;
        end else if (neg_a[DivCells][i]) begin
          unit_r[i] <= ~quo_a[i][DivCells] + 32'd1;
        end else begin
          unit_r[i] <= quo_a[i][DivCells];
        end
      end
      len_out_r  <= len_a[DivCells];
      zero_out_r <= zero_a[DivCells];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_unit      = unit_r[0];
  assign out_y_unit      = unit_r[1];
  assign out_z_unit      = unit_r[2];
  assign out_length_out  = len_out_r;
  assign out_zero_vector = zero_out_r;

endmodule

>>> hw/rtl/v3n_checker.sv
// Port-level checks for the vector normalizer, bound to the top level.
module v3n_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x_unit,
  input logic [31:0] out_y_unit,
  input logic [31:0] out_z_unit,
  input logic [31:0] out_length_out,
  input logic        out_zero_vector
);

  a_reset_empty: assert property (@(posedge clk) !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_zero_forces: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_vector |->
      out_x_unit == 32'd0 && out_y_unit == 32'd0 && out_z_unit == 32'd0)
    else $error("zero vector with nonzero components");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_vector |-> out_length_out != 32'd0)
    else $error("division result for zero length");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_length_out) &&
      $stable(out_x_unit) && $stable(out_zero_vector))
    else $error("stalled result changed");

endmodule

bind vector3_normalize_top v3n_checker u_v3n_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_x_unit      (out_x_unit),
  .out_y_unit      (out_y_unit),
  .out_z_unit      (out_z_unit),
  .out_length_out  (out_length_out),
  .out_zero_vector (out_zero_vector)
);

>>> tb/vector3_normalize_checker.sv
// Request and result monitor with a normalization predictor and an in-order compare.
module vector3_normalize_checker import v3n_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [ThreshW-1:0] cfg_zero_threshold,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_x_in,
  input  logic signed [31:0] in_y_in,
  input  logic signed [31:0] in_z_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_x_unit,
  input  logic signed [31:0] out_y_unit,
  input  logic signed [31:0] out_z_unit,
  input  logic        [31:0] out_length_out,
  input  logic               out_zero_vector,
  output int                 fail_count,
  output int                 pending,
  output int                 req_seen,
  output int                 res_seen,
  output int                 zero_seen
);

  typedef struct packed {
    logic [31:0] xu;
    logic [31:0] yu;
    logic [31:0] zu;
    logic [31:0] len;
    logic        zflag;
  } unit_vec_t;

  unit_vec_t        unit_queue[$];
  logic [ThreshW-1:0] thresh_copy;

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] cand;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  function automatic unit_vec_t normalize(input logic signed [31:0] c0,
                                          input logic signed [31:0] c1,
                                          input logic signed [31:0] c2,
                                          input logic [ThreshW-1:0] th);
    logic signed [31:0] comp[3];
    logic [63:0] mag[3];
    logic [63:0] sum;
    logic [63:0] len;
    logic [31:0] q[3];
    unit_vec_t r;
    comp[0] = c0;
    comp[1] = c1;
    comp[2] = c2;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i][31] ? 64'(-{32'hFFFF_FFFF, comp[i]}) : 64'(comp[i]);
      mag[i] = mag[i] & 64'hFFFF_FFFF;
      sum += mag[i] * mag[i];
    end
    len = isqrt64(sum);
    r.len = len[31:0];
    if (len == 0 || len < 64'(th)) begin
      r.xu = 0;
      r.yu = 0;
      r.zu = 0;
      r.zflag = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        q[i] = 32'((mag[i] << UnitShift) / len);
        if (comp[i][31]) q[i] = -q[i];
      end
      r.xu = q[0];
      r.yu = q[1];
      r.zu = q[2];
      r.zflag = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    unit_vec_t want;
    if (!rst_n) begin
      thresh_copy <= ThreshW'(1);
    end else begin
      if (cfg_we) thresh_copy <= cfg_zero_threshold;
      if (in_valid && !in_stall)
        unit_queue.push_back(normalize(in_x_in, in_y_in, in_z_in, thresh_copy));
      if (in_valid && !in_stall) req_seen++;
      if (out_valid && !out_stall) begin
        res_seen++;
        if (out_zero_vector) zero_seen++;
        if (unit_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result len=%h", $time, out_length_out);
        end else begin
          want = unit_queue.pop_front();
          if (want.xu !== out_x_unit || want.yu !== out_y_unit ||
              want.zu !== out_z_unit || want.len !== out_length_out ||
              want.zflag !== out_zero_vector) begin
            fail_count++;
            $display("%0t: mismatch expected x=%h y=%h z=%h len=%h zero=%b", $time,
                     want.xu, want.yu, want.zu, want.len, want.zflag);
            $display("%0t:          actual   x=%h y=%h z=%h len=%h zero=%b", $time,
                     out_x_unit, out_y_unit, out_z_unit, out_length_out,
                     out_zero_vector);
          end
        end
      end
    end
    pending <= unit_queue.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    req_seen = 0;
    res_seen = 0;
    zero_seen = 0;
  end

endmodule

>>> tb/vector3_normalize_top_tb.sv
// Testbench top: clock, reset, vector stimulus, threshold phases and the verdict.
module vector3_normalize_top_tb;
  import v3n_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [ThreshW-1:0] cfg_zero_threshold;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_x_in;
  logic signed [31:0] in_y_in;
  logic signed [31:0] in_z_in;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_x_unit;
  logic signed [31:0] out_y_unit;
  logic signed [31:0] out_z_unit;
  logic        [31:0] out_length_out;
  logic               out_zero_vector;

  int fail_count;
  int pending;
  int req_seen;
  int res_seen;
  int zero_seen;

  // Idling percentages for each side; the stimulus changes them per phase.
  int send_idle_pct;
  int recv_stall_pct;
  // When set, the receiver holds stall high for a long, counted stretch.
  logic hold_off;
  int   quiet_cycles;

  localparam int WatchdogLimit = 5000;
  // The pipeline is 100 deep; this covers draining plus a margin.
  localparam int DrainCycles = 150;

  vector3_normalize_top dut (.*);

  vector3_normalize_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_zero_threshold,
    .in_valid, .in_stall, .in_x_in, .in_y_in, .in_z_in,
    .out_valid, .out_stall, .out_x_unit, .out_y_unit, .out_z_unit,
    .out_length_out, .out_zero_vector,
    .fail_count, .pending, .req_seen, .res_seen, .zero_seen
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random, except during a forced hold-off.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // The watchdog ends the run when nothing moves on either channel for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off) begin
        quiet_cycles = 0;
      end else if (rst_n && (in_valid || pending > 0)) begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: no request or result moved for %0d cycles", WatchdogLimit);
        $display("FAIL vector3_normalize_top");
        $finish;
      end
    end
  end

  // Offers one request, idling first at the current rate, and waits for acceptance.
  // Valid stays high after acceptance so that requests can follow back to back.
  task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_x_in  <= x;
    in_y_in  <= y;
    in_z_in  <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every predicted result has come back and the pipeline is empty.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [ThreshW-1:0] th);
    cfg_we <= 1'b1;
    cfg_zero_threshold <= th;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A random component: mostly full range, sometimes small or near an extreme,
  // so that short vectors hit the threshold and long ones test the root width.
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom_range(200) - 100;
      1: return $urandom_range(1 << 18) - (1 << 17);
      2: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(15)
                                  : 32'h7FFF_FFFF - $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      // Every fourth segment of 40 requests runs with no idling at all.
      if ((i / 40) % 4 == 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
      end
      send_vector(rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_zero_threshold = '0;
    in_valid = 1'b0;
    in_x_in = '0;
    in_y_in = '0;
    in_z_in = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed vectors with the reset threshold of one LSB: the zero vector,
    // the smallest nonzero lengths, unit axes, extremes and mixed signs.
    send_vector(0, 0, 0);
    send_vector(1, 0, 0);
    send_vector(0, 32'hFFFF_FFFF, 0);
    send_vector(0, 0, 32'h0001_0000);
    send_vector(32'hFFFF_0000, 0, 0);
    send_vector(32'h7FFF_FFFF, 0, 0);
    send_vector(32'h8000_0000, 0, 0);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vector(32'h0003_0000, 32'hFFFC_0000, 0);
    send_vector(1, 1, 1);
    send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
    drain();

    // A zero threshold: only a length of exactly zero counts as degenerate.
    write_threshold(17'd0);
    send_vector(0, 0, 0);
    send_vector(1, 0, 0);
    send_vector(0, 32'hFFFF_FFFF, 1);
    drain();

    // A threshold of 1.0: vectors just below and at unit length.
    write_threshold(17'h1_0000);
    send_vector(32'h0000_FFFF, 0, 0);
    send_vector(32'h0001_0000, 0, 0);
    send_vector(0, 32'hFFFF_0001, 0);
    send_vector(32'h0000_93CD, 32'h0000_93CD, 32'h0000_93CD);
    drain();

    // Random phases across several thresholds and idling patterns.
    write_threshold(17'h1_FFFF);
    random_phase(300, 0, 0);
    drain();
    write_threshold(17'h0_0100);
    random_phase(300, 75, 0);
    drain();
    write_threshold(17'd1);
    random_phase(300, 0, 75);
    drain();
    write_threshold(ThreshW'($urandom_range(17'h1_FFFF)));
    random_phase(200, 14, 14);
    drain();

    // Back-pressure: the receiver holds off for a long stretch while requests
    // keep coming, so the pipeline fills and the input stall must assert.
    write_threshold(17'h0_8000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 150; i++) send_vector(rand_comp(), rand_comp(), rand_comp());
      end
    join
    drain();

    $display("covered %0d requests and %0d results, %0d of them zero vectors,",
             req_seen, res_seen, zero_seen);
    $display("over several thresholds, four idling patterns and a long receiver hold-off");
    if (fail_count == 0) begin
      $display("PASS vector3_normalize_top");
    end else begin
      $display("FAIL vector3_normalize_top");
    end
    $finish;
  end

endmodule
